// ===== rtl/lbo_pkg.sv =====
package lbo_pkg;

    localparam int OUT_LAMPS = 8;

    typedef enum logic [1:0] {
        MODE_TICK      = 2'd0,
        MODE_SET_BASE  = 2'd1,
        MODE_SET_OVR   = 2'd2,
        MODE_CLEAR_OVR = 2'd3
    } t_mode;

    typedef logic [1:0] t_pattern;

    localparam t_pattern PAT_OFF   = 2'd0;
    localparam t_pattern PAT_SOLID = 2'd1;
    localparam t_pattern PAT_BLINK = 2'd2;

    typedef logic [2:0]  t_lamp_idx;
    typedef logic [31:0] t_ms;
    typedef logic [7:0]  t_prio;
    typedef logic [OUT_LAMPS-1:0] t_lamp_mask;

endpackage

// ===== rtl/lbo_if.sv =====
interface lbo_cmd_if;
    logic              valid;
    logic              ready;
    lbo_pkg::t_mode    mode;
    lbo_pkg::t_lamp_idx lamp;
    lbo_pkg::t_pattern pattern;
    lbo_pkg::t_ms      interval_ms;
    lbo_pkg::t_ms      duration_ms;
    lbo_pkg::t_prio    priority_req;

    modport source (
        output valid, mode, lamp, pattern, interval_ms, duration_ms, priority_req,
        input  ready
    );
    modport sink (
        input  valid, mode, lamp, pattern, interval_ms, duration_ms, priority_req,
        output ready
    );
endinterface

interface lbo_res_if;
    logic                  valid;
    logic                  ready;
    lbo_pkg::t_lamp_mask   lamp_levels;
    lbo_pkg::t_lamp_mask   changed_mask;

    modport source (
        output valid, lamp_levels, changed_mask,
        input  ready
    );
    modport sink (
        input  valid, lamp_levels, changed_mask,
        output ready
    );
endinterface

// ===== rtl/led_blink_override_controller_unit.sv =====
// An input item is registered at the edge that accepts it and is then processed from that register.
// Each item takes a single pass through the per-lamp logic; a tick's result is then registered.
// One item is accepted every cycle, except while a tick waits for a stalled result register.
// A tick waits in the input register only while the result register is full and stalled.
// Synchronous active-low reset clears the time counter and all lamp state: lamps are off.
module led_blink_override_controller_unit #(
    parameter int LAMP_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lbo_cmd_if.sink    i_cmd,
    lbo_res_if.source  o_res
);

    logic                r_in_valid;
    lbo_pkg::t_mode      r_mode;
    lbo_pkg::t_lamp_idx  r_lamp;
    lbo_pkg::t_pattern   r_pattern;
    lbo_pkg::t_ms        r_interval;
    lbo_pkg::t_ms        r_duration;
    lbo_pkg::t_prio      r_priority;

    lbo_pkg::t_ms        r_time;
    lbo_pkg::t_pattern   r_base_pat   [LAMP_COUNT];
    lbo_pkg::t_ms        r_base_ivl   [LAMP_COUNT];
    lbo_pkg::t_pattern   r_ovr_pat    [LAMP_COUNT];
    lbo_pkg::t_ms        r_ovr_ivl    [LAMP_COUNT];
    lbo_pkg::t_prio      r_ovr_prio   [LAMP_COUNT];
    logic                r_ovr_active [LAMP_COUNT];
    logic                r_ovr_expires[LAMP_COUNT];
    lbo_pkg::t_ms        r_ovr_dead   [LAMP_COUNT];
    logic                r_phase      [LAMP_COUNT];
    lbo_pkg::t_ms        r_last       [LAMP_COUNT];
    logic                r_lamp_on    [LAMP_COUNT];

    lbo_pkg::t_pattern   n_base_pat   [LAMP_COUNT];
    lbo_pkg::t_ms        n_base_ivl   [LAMP_COUNT];
    lbo_pkg::t_pattern   n_ovr_pat    [LAMP_COUNT];
    lbo_pkg::t_ms        n_ovr_ivl    [LAMP_COUNT];
    lbo_pkg::t_prio      n_ovr_prio   [LAMP_COUNT];
    logic                n_ovr_active [LAMP_COUNT];
    logic                n_ovr_expires[LAMP_COUNT];
    lbo_pkg::t_ms        n_ovr_dead   [LAMP_COUNT];
    logic                n_phase      [LAMP_COUNT];
    lbo_pkg::t_ms        n_last       [LAMP_COUNT];
    logic                n_lamp_on    [LAMP_COUNT];
    logic                n_diff       [LAMP_COUNT];

    logic                r_out_valid;
    lbo_pkg::t_lamp_mask r_levels;
    lbo_pkg::t_lamp_mask r_changed;
    lbo_pkg::t_lamp_mask n_levels;
    lbo_pkg::t_lamp_mask n_changed;

    logic                is_tick;
    logic                advance;
    lbo_pkg::t_ms        time_next;

    assign is_tick   = (r_mode == lbo_pkg::MODE_TICK);
    assign advance   = r_in_valid && (!is_tick || !r_out_valid || o_res.ready);
    assign time_next = r_time + 32'd1;

    assign i_cmd.ready        = !r_in_valid || advance;
    assign o_res.valid        = r_out_valid;
    assign o_res.lamp_levels  = r_levels;
    assign o_res.changed_mask = r_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_mode     <= i_cmd.mode;
            r_lamp     <= i_cmd.lamp;
            r_pattern  <= i_cmd.pattern;
            r_interval <= i_cmd.interval_ms;
            r_duration <= i_cmd.duration_ms;
            r_priority <= i_cmd.priority_req;
        end
    end

    always_comb begin
        for (int n = 0; n < LAMP_COUNT; n++) begin
            logic              sel;
            logic              expire;
            logic              act;
            lbo_pkg::t_pattern pat;
            lbo_pkg::t_ms      ivl;
            logic              toggle;

            n_base_pat[n]    = r_base_pat[n];
            n_base_ivl[n]    = r_base_ivl[n];
            n_ovr_pat[n]     = r_ovr_pat[n];
            n_ovr_ivl[n]     = r_ovr_ivl[n];
            n_ovr_prio[n]    = r_ovr_prio[n];
            n_ovr_active[n]  = r_ovr_active[n];
            n_ovr_expires[n] = r_ovr_expires[n];
            n_ovr_dead[n]    = r_ovr_dead[n];
            n_phase[n]       = r_phase[n];
            n_last[n]        = r_last[n];
            n_lamp_on[n]     = r_lamp_on[n];
            n_diff[n]        = 1'b0;

            sel    = (32'(r_lamp) == 32'(n));
            expire = r_ovr_active[n] && r_ovr_expires[n] && (time_next == r_ovr_dead[n]);
            act    = r_ovr_active[n] && !expire;
            pat    = act ? r_ovr_pat[n] : r_base_pat[n];
            ivl    = act ? r_ovr_ivl[n] : r_base_ivl[n];
            toggle = (pat == lbo_pkg::PAT_BLINK) && ((time_next - r_last[n]) >= ivl);

            unique case (r_mode)
                lbo_pkg::MODE_TICK: begin
                    n_ovr_active[n] = act;
                    if (toggle) begin
                        n_last[n]  = time_next;
                        n_phase[n] = !r_phase[n];
                    end
                    n_lamp_on[n] = (pat == lbo_pkg::PAT_SOLID) ||
                                   ((pat == lbo_pkg::PAT_BLINK) && n_phase[n]);
                    n_diff[n]    = (n_lamp_on[n] != r_lamp_on[n]);
                end
                lbo_pkg::MODE_SET_BASE: begin
                    if (sel) begin
                        n_base_pat[n] = r_pattern;
                        n_base_ivl[n] = r_interval;
                        n_phase[n]    = 1'b1;
                        n_last[n]     = r_time;
                    end
                end
                lbo_pkg::MODE_SET_OVR: begin
                    if (sel && !(r_ovr_active[n] && (r_ovr_prio[n] > r_priority))) begin
                        n_ovr_pat[n]     = r_pattern;
                        n_ovr_ivl[n]     = r_interval;
                        n_ovr_prio[n]    = r_priority;
                        n_ovr_expires[n] = (r_duration != 32'd0);
                        n_ovr_dead[n]    = r_time + r_duration;
                        n_ovr_active[n]  = 1'b1;
                        n_phase[n]       = 1'b1;
                        n_last[n]        = r_time;
                    end
                end
                lbo_pkg::MODE_CLEAR_OVR: begin
                    if (sel && r_ovr_active[n]) begin
                        n_ovr_active[n] = 1'b0;
                        n_phase[n]      = 1'b1;
                        n_last[n]       = r_time;
                    end
                end
            endcase
        end
    end

    for (genvar g = 0; g < lbo_pkg::OUT_LAMPS; g++) begin : g_out
        if (g < LAMP_COUNT) begin : g_lamp
            assign n_levels[g]  = n_lamp_on[g];
            assign n_changed[g] = n_diff[g];
        end else begin : g_none
            assign n_levels[g]  = 1'b0;
            assign n_changed[g] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            for (int n = 0; n < LAMP_COUNT; n++) begin
                r_base_pat[n]    <= lbo_pkg::PAT_OFF;
                r_base_ivl[n]    <= '0;
                r_ovr_pat[n]     <= lbo_pkg::PAT_OFF;
                r_ovr_ivl[n]     <= '0;
                r_ovr_prio[n]    <= '0;
                r_ovr_active[n]  <= 1'b0;
                r_ovr_expires[n] <= 1'b0;
                r_ovr_dead[n]    <= '0;
                r_phase[n]       <= 1'b0;
                r_last[n]        <= '0;
                r_lamp_on[n]     <= 1'b0;
            end
        end else if (advance) begin
            if (is_tick) begin
                r_time <= time_next;
            end
            for (int n = 0; n < LAMP_COUNT; n++) begin
                r_base_pat[n]    <= n_base_pat[n];
                r_base_ivl[n]    <= n_base_ivl[n];
                r_ovr_pat[n]     <= n_ovr_pat[n];
                r_ovr_ivl[n]     <= n_ovr_ivl[n];
                r_ovr_prio[n]    <= n_ovr_prio[n];
                r_ovr_active[n]  <= n_ovr_active[n];
                r_ovr_expires[n] <= n_ovr_expires[n];
                r_ovr_dead[n]    <= n_ovr_dead[n];
                r_phase[n]       <= n_phase[n];
                r_last[n]        <= n_last[n];
                r_lamp_on[n]     <= n_lamp_on[n];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_tick) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_tick) begin
            r_levels  <= n_levels;
            r_changed <= n_changed;
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int LAMPS = 8;
    localparam int CLK_HALF = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam lbo_pkg::t_pattern PAT_RESERVED = 2'd3;
    localparam lbo_pkg::t_ms MS_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        lbo_pkg::t_lamp_mask levels;
        lbo_pkg::t_lamp_mask changed;
    } t_lamp_frame;

    logic i_clk;
    logic i_rst_n;

    lbo_cmd_if cmd_ch ();
    lbo_res_if res_ch ();

    led_blink_override_controller_unit #(
        .LAMP_COUNT(LAMPS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch)
    );

    // Shadow copy of the lamp controller state.
    lbo_pkg::t_ms      now_ms;
    lbo_pkg::t_pattern base_pat   [LAMPS];
    lbo_pkg::t_ms      base_ivl   [LAMPS];
    lbo_pkg::t_pattern ovr_pat    [LAMPS];
    lbo_pkg::t_ms      ovr_ivl    [LAMPS];
    lbo_pkg::t_prio    ovr_prio   [LAMPS];
    bit                ovr_live   [LAMPS];
    bit                ovr_timed  [LAMPS];
    lbo_pkg::t_ms      ovr_due    [LAMPS];
    bit                phase_on   [LAMPS];
    lbo_pkg::t_ms      toggled_at [LAMPS];
    bit                lit        [LAMPS];

    t_lamp_frame frames_due[$];

    int unsigned cycle_count = 0;
    int unsigned items_sent;
    int unsigned ticks_sent;
    int unsigned frames_checked = 0;
    int unsigned mismatches = 0;
    int unsigned ovr_blocked;
    int unsigned ovr_expired;
    int unsigned burst_left;
    bit          sender_gaps;
    bit          sink_stalls;
    logic [7:0]  stall_step;
    logic [15:0] stall_bits;

    function automatic void clear_lamp_model();
        now_ms = '0;
        for (int n = 0; n < LAMPS; n++) begin
            base_pat[n]   = lbo_pkg::PAT_OFF;
            base_ivl[n]   = '0;
            ovr_pat[n]    = lbo_pkg::PAT_OFF;
            ovr_ivl[n]    = '0;
            ovr_prio[n]   = '0;
            ovr_live[n]   = 1'b0;
            ovr_timed[n]  = 1'b0;
            ovr_due[n]    = '0;
            phase_on[n]   = 1'b0;
            toggled_at[n] = '0;
            lit[n]        = 1'b0;
        end
    endfunction

    function automatic t_lamp_frame advance_one_ms();
        t_lamp_frame       f;
        lbo_pkg::t_pattern p;
        lbo_pkg::t_ms      iv;
        lbo_pkg::t_ms      elapsed;
        bit                want;
        f = '0;
        now_ms = now_ms + 32'd1;
        for (int n = 0; n < LAMPS; n++) begin
            if (ovr_live[n] && ovr_timed[n] && now_ms == ovr_due[n]) begin
                ovr_live[n] = 1'b0;
                ovr_expired++;
            end
            p = ovr_live[n] ? ovr_pat[n] : base_pat[n];
            iv = ovr_live[n] ? ovr_ivl[n] : base_ivl[n];
            elapsed = now_ms - toggled_at[n];
            if (p == lbo_pkg::PAT_BLINK && elapsed >= iv) begin
                toggled_at[n] = now_ms;
                phase_on[n] = !phase_on[n];
            end
            if (p == lbo_pkg::PAT_SOLID) begin
                want = 1'b1;
            end else if (p == lbo_pkg::PAT_BLINK) begin
                want = phase_on[n];
            end else begin
                want = 1'b0;
            end
            if (want != lit[n]) begin
                lit[n] = want;
                f.changed[n] = 1'b1;
            end
            f.levels[n] = lit[n];
        end
        return f;
    endfunction

    function automatic void apply_lamp_command(lbo_pkg::t_mode mode, lbo_pkg::t_lamp_idx lamp,
                                               lbo_pkg::t_pattern pat, lbo_pkg::t_ms ivl,
                                               lbo_pkg::t_ms dur, lbo_pkg::t_prio prio);
        int n;
        n = lamp;
        if (n >= LAMPS) begin
            return;
        end
        case (mode)
            lbo_pkg::MODE_SET_BASE: begin
                base_pat[n] = pat;
                base_ivl[n] = ivl;
                phase_on[n] = 1'b1;
                toggled_at[n] = now_ms;
            end
            lbo_pkg::MODE_SET_OVR: begin
                if (ovr_live[n] && ovr_prio[n] > prio) begin
                    ovr_blocked++;
                end else begin
                    ovr_pat[n]   = pat;
                    ovr_ivl[n]   = ivl;
                    ovr_prio[n]  = prio;
                    ovr_timed[n] = (dur != 0);
                    ovr_due[n]   = now_ms + dur;
                    ovr_live[n]  = 1'b1;
                    phase_on[n]  = 1'b1;
                    toggled_at[n] = now_ms;
                end
            end
            lbo_pkg::MODE_CLEAR_OVR: begin
                if (ovr_live[n]) begin
                    ovr_live[n] = 1'b0;
                    phase_on[n] = 1'b1;
                    toggled_at[n] = now_ms;
                end
            end
            default: begin
            end
        endcase
    endfunction

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    task automatic send_item(input lbo_pkg::t_mode mode, input lbo_pkg::t_lamp_idx lamp,
                             input lbo_pkg::t_pattern pat, input lbo_pkg::t_ms ivl,
                             input lbo_pkg::t_ms dur, input lbo_pkg::t_prio prio);
        int unsigned gap;
        cmd_ch.valid        <= 1'b1;
        cmd_ch.mode         <= mode;
        cmd_ch.lamp         <= lamp;
        cmd_ch.pattern      <= pat;
        cmd_ch.interval_ms  <= ivl;
        cmd_ch.duration_ms  <= dur;
        cmd_ch.priority_req <= prio;
        do @(posedge i_clk); while (!cmd_ch.ready);
        items_sent++;
        if (mode == lbo_pkg::MODE_TICK) begin
            ticks_sent++;
            frames_due.push_back(advance_one_ms());
        end else begin
            apply_lamp_command(mode, lamp, pat, ivl, dur, prio);
        end
        if (sender_gaps) begin
            if (burst_left <= 1) begin
                gap = $urandom_range(1, 5);
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Fields are don't-care on a tick, so they carry random noise.
    task automatic send_tick();
        send_item(lbo_pkg::MODE_TICK, lbo_pkg::t_lamp_idx'($urandom),
                  lbo_pkg::t_pattern'($urandom), lbo_pkg::t_ms'($urandom),
                  lbo_pkg::t_ms'($urandom), lbo_pkg::t_prio'($urandom));
    endtask

    task automatic wait_for_drain();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (frames_due.size() != 0);
    endtask

    function automatic lbo_pkg::t_ms pick_interval();
        case ($urandom_range(0, 9))
            0:       return lbo_pkg::t_ms'($urandom);
            1:       return MS_MAX;
            default: return lbo_pkg::t_ms'($urandom_range(0, 6));
        endcase
    endfunction

    function automatic lbo_pkg::t_ms pick_duration();
        case ($urandom_range(0, 9))
            0:       return lbo_pkg::t_ms'($urandom);
            1, 2:    return '0;
            default: return lbo_pkg::t_ms'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic lbo_pkg::t_pattern pick_pattern();
        case ($urandom_range(0, 9))
            0:       return PAT_RESERVED;
            1, 2:    return lbo_pkg::PAT_OFF;
            3, 4, 5: return lbo_pkg::PAT_SOLID;
            default: return lbo_pkg::PAT_BLINK;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_step   <= '0;
            stall_bits   <= 16'hA5C3;
            res_ch.ready <= 1'b0;
        end else begin
            stall_step <= stall_step + 8'd1;
            if (stall_step == 8'd0) begin
                stall_bits <= 16'($urandom);
            end
            if (!sink_stalls || stall_step[7]) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= stall_bits[stall_step[3:0]];
            end
        end
    end

    always @(posedge i_clk) begin
        t_lamp_frame want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Unexpected result: levels %b changed %b",
                             res_ch.lamp_levels, res_ch.changed_mask);
                end
            end else begin
                want = frames_due.pop_front();
                frames_checked++;
                if (res_ch.lamp_levels !== want.levels) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Result %0d lamp_levels: expected %b, got %b",
                                 frames_checked, want.levels, res_ch.lamp_levels);
                    end
                end
                if (res_ch.changed_mask !== want.changed) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Result %0d changed_mask: expected %b, got %b",
                                 frames_checked, want.changed, res_ch.changed_mask);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, frames_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_idle_after_reset();
        send_tick();
        send_tick();
    endtask

    task automatic test_base_patterns();
        send_item(lbo_pkg::MODE_SET_BASE, 3'd0, lbo_pkg::PAT_SOLID, '0, '0, '0);
        send_item(lbo_pkg::MODE_SET_BASE, 3'd1, lbo_pkg::PAT_BLINK, '0, MS_MAX, 8'hFF);
        send_item(lbo_pkg::MODE_SET_BASE, 3'd7, lbo_pkg::PAT_BLINK, MS_MAX, '0, '0);
        send_item(lbo_pkg::MODE_SET_BASE, 3'd2, PAT_RESERVED, 32'd1, '0, '0);
        send_item(lbo_pkg::MODE_SET_BASE, 3'd4, lbo_pkg::PAT_BLINK, 32'd2, '0, '0);
        send_tick();
        send_tick();
        send_tick();
    endtask

    task automatic test_override_priority();
        send_item(lbo_pkg::MODE_SET_OVR, 3'd0, lbo_pkg::PAT_OFF, '0, '0, 8'd200);
        send_item(lbo_pkg::MODE_SET_OVR, 3'd0, lbo_pkg::PAT_SOLID, '0, '0, 8'd100);
        send_tick();
        send_item(lbo_pkg::MODE_SET_OVR, 3'd0, lbo_pkg::PAT_BLINK, 32'd1, '0, 8'd200);
        send_item(lbo_pkg::MODE_SET_OVR, 3'd1, lbo_pkg::PAT_SOLID, '0, '0, 8'd0);
        send_tick();
        send_item(lbo_pkg::MODE_CLEAR_OVR, 3'd0, lbo_pkg::PAT_OFF, '0, '0, '0);
        send_item(lbo_pkg::MODE_CLEAR_OVR, 3'd5, lbo_pkg::PAT_SOLID, '0, '0, 8'hFF);
        send_item(lbo_pkg::MODE_SET_BASE, 3'd1, lbo_pkg::PAT_OFF, '0, '0, '0);
        send_tick();
    endtask

    task automatic test_override_expiry();
        send_item(lbo_pkg::MODE_SET_OVR, 3'd6, lbo_pkg::PAT_SOLID, '0, 32'd1, 8'd5);
        send_item(lbo_pkg::MODE_SET_OVR, 3'd3, lbo_pkg::PAT_SOLID, '0, MS_MAX, 8'hFF);
        send_item(lbo_pkg::MODE_SET_OVR, 3'd2, lbo_pkg::PAT_BLINK, '0, 32'd3, 8'd1);
        send_tick();
        send_tick();
        send_tick();
        send_tick();
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_tick();
            end else if (pick < 65) begin
                send_item(lbo_pkg::MODE_SET_BASE, lbo_pkg::t_lamp_idx'($urandom),
                          pick_pattern(), pick_interval(),
                          lbo_pkg::t_ms'($urandom), lbo_pkg::t_prio'($urandom));
            end else if (pick < 90) begin
                send_item(lbo_pkg::MODE_SET_OVR, lbo_pkg::t_lamp_idx'($urandom),
                          pick_pattern(), pick_interval(),
                          pick_duration(), lbo_pkg::t_prio'($urandom));
            end else begin
                send_item(lbo_pkg::MODE_CLEAR_OVR, lbo_pkg::t_lamp_idx'($urandom),
                          lbo_pkg::t_pattern'($urandom), lbo_pkg::t_ms'($urandom),
                          lbo_pkg::t_ms'($urandom), lbo_pkg::t_prio'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.mode         <= lbo_pkg::MODE_TICK;
        cmd_ch.lamp         <= '0;
        cmd_ch.pattern      <= lbo_pkg::PAT_OFF;
        cmd_ch.interval_ms  <= '0;
        cmd_ch.duration_ms  <= '0;
        cmd_ch.priority_req <= '0;
        items_sent     = 0;
        ticks_sent     = 0;
        ovr_blocked    = 0;
        ovr_expired    = 0;
        burst_left     = 1;
        sender_gaps    = 1'b0;
        sink_stalls    = 1'b0;
        clear_lamp_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_after_reset();
        test_base_patterns();
        test_override_priority();
        test_override_expiry();

        test_random_traffic(200);
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        test_random_traffic(650);
        wait_for_drain();
        test_random_traffic(650);

        wait_for_drain();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d items (%0d ticks) and checked %0d lamp frames.",
                 items_sent, ticks_sent, frames_checked);
        $display("Overrides blocked by priority: %0d, overrides expired: %0d.",
                 ovr_blocked, ovr_expired);
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results outstanding.", mismatches, frames_due.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lbo_pkg.sv
rtl/lbo_if.sv
rtl/led_blink_override_controller_unit.sv
verif/testbench.sv
